>>> rtl/core/t8ce_pkg.sv
`timescale 1ns / 1ps
package t8ce_pkg;

    localparam int MEM_DEPTH_DEF  = 256;
    localparam int STACK_SIZE_DEF = 255;
    localparam int ROM_LIMIT_DEF  = 1024;

    localparam logic [7:0] FLAG_EQ = 8'h01;
    localparam logic [7:0] FLAG_LT = 8'h02;
    localparam logic [7:0] FLAG_GT = 8'h04;

    localparam logic [7:0] OP_NOP     = 8'h00;
    localparam logic [7:0] OP_SHIFT   = 8'h13;
    localparam logic [7:0] OP_CMP     = 8'h19;
    localparam logic [7:0] OP_JMP     = 8'h25;
    localparam logic [7:0] OP_PUSH    = 8'h43;
    localparam logic [7:0] OP_POP     = 8'h48;
    localparam logic [7:0] OP_LOGIC   = 8'h4B;
    localparam logic [7:0] OP_HOLE    = 8'h60;
    localparam logic [7:0] OP_PUSHV   = 8'h79;
    localparam logic [7:0] OP_PUSHM   = 8'h7A;
    localparam logic [7:0] OP_POPM    = 8'h7B;
    localparam logic [7:0] OP_MEMMEM  = 8'h7C;
    localparam logic [7:0] OP_LAST    = 8'h8A;

    localparam logic [2:0] ERR_OK    = 3'd0;
    localparam logic [2:0] ERR_OP    = 3'd1;
    localparam logic [2:0] ERR_FULL  = 3'd2;
    localparam logic [2:0] ERR_EMPTY = 3'd3;
    localparam logic [2:0] ERR_ROM   = 3'd4;

    // operand source
    typedef enum logic [2:0] {
        SRC_NONE = 3'd0,
        SRC_IMM  = 3'd1,
        SRC_MEMP = 3'd2,
        SRC_MEMQ = 3'd3,
        SRC_REG  = 3'd4,
        SRC_Q    = 3'd5
    } src_t;

    typedef enum logic [3:0] {
        ALU_MOV = 4'd0, ALU_ADD = 4'd1, ALU_SUB = 4'd2, ALU_SHL = 4'd3,
        ALU_SHR = 4'd4, ALU_OR  = 4'd5, ALU_AND = 4'd6, ALU_XOR = 4'd7,
        ALU_CMP = 4'd8, ALU_CMPR = 4'd9, ALU_JMP = 4'd10, ALU_PUSH = 4'd11,
        ALU_POP = 4'd12, ALU_NONE = 4'd13
    } alu_t;

    // dst: 0 acc 1 x 2 y 3 mem(p) 4 none
    typedef struct packed {
        alu_t       alu;
        src_t       src;
        logic [1:0] src_reg;
        logic [1:0] src_misc;   // push: 0 reg 1 flags 2 depth 3 operand
        logic [2:0] dst;
        logic [2:0] cond;
        logic [1:0] len;
        logic       push;
        logic       pop;
    } dec_t;

    // quotient of a small value by a small constant, by parallel compares
    function automatic logic [7:0] quo_small(input logic [7:0] k, input logic [7:0] m);
        logic [7:0] q;
        q = 8'd0;
        for (int i = 1; i < 9; i++)
        begin
            if ({8'd0, k} >= 16'(m * i)) q = q + 8'd1;
        end
        return q;
    endfunction

    function automatic logic [7:0] rem_small(input logic [7:0] k, input logic [7:0] m);
        return k - 8'(quo_small(k, m) * m);
    endfunction

    function automatic dec_t decode(input logic [7:0] op);
        dec_t d;
        logic [7:0] k;
        logic [7:0] g;
        logic [7:0] s;
        d = '{alu: ALU_NONE, src: SRC_NONE, src_reg: 2'd0, src_misc: 2'd0,
              dst: 3'd4, cond: 3'd0, len: 2'd0, push: 1'b0, pop: 1'b0};
        k = 8'd0; g = 8'd0; s = 8'd0;
        if (op == OP_NOP) begin
            d.len = 2'd1;
        end else if (op < OP_SHIFT) begin
            k = op - 8'd1;
            g = quo_small(k, 8'd6);
            d.alu = (g == 8'd0) ? ALU_MOV : ((g == 8'd1) ? ALU_ADD : ALU_SUB);
            d.src = k[0] ? SRC_MEMP : SRC_IMM;
            d.dst = 3'(rem_small(k, 8'd6) >> 1);
            d.len = 2'd2;
        end else if (op < OP_CMP) begin
            k = op - OP_SHIFT;
            d.alu = (k < 8'd3) ? ALU_SHL : ALU_SHR;
            d.dst = 3'(rem_small(k, 8'd3));
            d.src = SRC_IMM;
            d.len = 2'd2;
        end else if (op < OP_JMP) begin
            k = op - OP_CMP;
            g = k >> 2;
            s = k & 8'd3;
            d.dst = 3'(g);
            if (s < 8'd2) begin
                d.alu = ALU_CMP;
                d.src = SRC_REG;
                if (g == 8'd0)      d.src_reg = 2'(s + 8'd1);
                else if (g == 8'd1) d.src_reg = (s == 8'd0) ? 2'd0 : 2'd2;
                else                d.src_reg = 2'(s);
                d.len = 2'd1;
            end else begin
                d.alu = (s == 8'd2) ? ALU_CMP : ALU_CMPR;
                d.src = SRC_IMM;
                d.len = 2'd2;
            end
        end else if (op <= 8'h40) begin
            k = op - OP_JMP;
            g = quo_small(k, 8'd7);
            d.alu = ALU_JMP;
            d.cond = 3'(rem_small(k, 8'd7));
            if (g == 8'd0) begin
                d.src = SRC_IMM;
                d.len = 2'd2;
            end else begin
                d.src = SRC_REG;
                d.src_reg = 2'(g - 8'd1);
                d.len = 2'd1;
            end
        end else if (op < OP_PUSH) begin
            d.len = 2'd0;
        end else if (op < OP_POP) begin
            k = op - OP_PUSH;
            d.alu = ALU_PUSH;
            d.push = 1'b1;
            d.len = 2'd1;
            d.src = SRC_REG;
            d.src_reg = 2'(k);
            d.src_misc = (k < 8'd3) ? 2'd0 : ((k == 8'd3) ? 2'd1 : 2'd2);
        end else if (op < OP_LOGIC) begin
            d.alu = ALU_POP;
            d.pop = 1'b1;
            d.dst = 3'(op - OP_POP);
            d.len = 2'd1;
        end else if (op < OP_PUSHV) begin
            if (op == OP_HOLE) begin
                d.len = 2'd0;
            end else begin
                k = (op < OP_HOLE) ? op - OP_LOGIC : op - 8'h4C;
                g = quo_small(k, 8'd5);
                s = rem_small(k, 8'd5);
                d.dst = 3'(rem_small(g, 8'd3));
                d.alu = (g < 8'd3) ? ALU_OR : ((g < 8'd6) ? ALU_AND : ALU_XOR);
                if (s < 8'd3) begin
                    d.src = SRC_REG;
                    d.src_reg = 2'(s);
                    d.len = 2'd1;
                end else begin
                    d.src = (s == 8'd3) ? SRC_IMM : SRC_MEMP;
                    d.len = 2'd2;
                end
            end
        end else if (op == OP_PUSHV || op == OP_PUSHM) begin
            d.alu = ALU_PUSH;
            d.push = 1'b1;
            d.src = (op == OP_PUSHV) ? SRC_IMM : SRC_MEMP;
            d.src_misc = 2'd3;
            d.len = 2'd2;
        end else if (op == OP_POPM) begin
            d.alu = ALU_POP;
            d.pop = 1'b1;
            d.dst = 3'd3;
            d.len = 2'd2;
        end else if (op <= OP_LAST) begin
            k = op - OP_MEMMEM;
            g = quo_small(k, 8'd5);
            s = rem_small(k, 8'd5);
            d.alu = (g == 8'd0) ? ALU_MOV : ((g == 8'd1) ? ALU_ADD : ALU_SUB);
            d.dst = 3'd3;
            if (s < 8'd3) begin
                d.src = SRC_REG;
                d.src_reg = 2'(s);
                d.len = 2'd2;
            end else begin
                d.src = (s == 8'd3) ? SRC_Q : SRC_MEMQ;
                d.len = 2'd3;
            end
        end
        return d;
    endfunction

endpackage

>>> rtl/core/tiny_8bit_cpu_execute.sv
`timescale 1ns / 1ps
// instruction execute block of a small 8-bit cpu
// input channel (in_valid/in_ready): one instruction word per handshake,
// opcode in mode plus operand_first and operand_second
// output channel (out_valid/out_ready): registers, flags, next pc and an
// error code after the instruction
// an accepted word has its data memory entries (operand and destination, two
// read ports) and the stack top read at the accepting edge; it executes and
// writes back once the output register is free, and out_valid is set by that
// execute; sustained rate is one word per cycle with no stall: the next word
// is read while the last one executes, with forwarding of its memory and stack
// writes; the output register lets a new word be read while the last result
// waits; while out_valid is held by a stalled receiver, execute of the next word waits
// reset clears registers and stack depth; the data memory is cleared by a pass
// over all entries after reset during which no word is accepted
module tiny_8bit_cpu_execute
    import t8ce_pkg::*;
#(
    parameter int MEM_DEPTH  = MEM_DEPTH_DEF,
    parameter int STACK_SIZE = STACK_SIZE_DEF,
    parameter int ROM_LIMIT  = ROM_LIMIT_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  mode,
    input  logic [7:0]  operand_first,
    input  logic [7:0]  operand_second,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  acc_out,
    output logic [7:0]  x_out,
    output logic [7:0]  y_out,
    output logic [7:0]  flags_out,
    output logic [15:0] next_pc,
    output logic [2:0]  error_code
);

    localparam int AW = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    localparam int SW = (STACK_SIZE > 1) ? $clog2(STACK_SIZE) : 1;
    localparam int RECIP = (65536 + MEM_DEPTH - 1) / MEM_DEPTH;

    // address byte modulo MEM_DEPTH by reciprocal multiplication
    function automatic logic [AW-1:0] addr_of(input logic [7:0] a);
        logic [23:0] prod;
        logic [7:0]  q;
        logic [15:0] qd;
        prod = {16'd0, a} * 24'(RECIP);
        q    = prod[23:16];
        qd   = {8'd0, q} * 16'(MEM_DEPTH);
        return AW'({8'd0, a} - qd);
    endfunction

    logic [7:0] mem [MEM_DEPTH];
    logic [7:0] stk [STACK_SIZE];

    logic [7:0]  acc_reg, x_reg, y_reg, flag_reg, depth_reg;
    logic [15:0] pc_reg;
    logic        clr_reg;
    logic [AW:0] clr_cnt_reg;

    // execute stage holding register
    logic        ex_valid_reg;
    logic [7:0]  ex_op_reg, ex_p_reg, ex_q_reg;
    logic [7:0]  rd_p_reg, rd_q_reg, rd_s_reg;

    logic        out_valid_reg;
    logic [7:0]  o_acc_reg, o_x_reg, o_y_reg, o_flag_reg;
    logic [15:0] o_pc_reg;
    logic [2:0]  o_err_reg;

    logic       ex_go;
    logic [AW-1:0] pa, qa, ex_pa;
    dec_t       d;
    logic [7:0] r_src, v, dv, res, jt, push_v;
    logic [8:0] dif;
    logic [2:0] err;
    logic       cond_ok;
    logic [16:0] pc_len;
    logic [7:0] flag_next;

    assign ex_go    = ex_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !clr_reg && (!ex_valid_reg || ex_go);
    assign pa       = addr_of(operand_first);
    assign qa       = addr_of(operand_second);
    assign ex_pa    = addr_of(ex_p_reg);

    assign d = decode(ex_op_reg);

    always_comb
    begin
        case (d.src_reg)
            2'd0:    r_src = acc_reg;
            2'd1:    r_src = x_reg;
            default: r_src = y_reg;
        endcase
        case (d.src)
            SRC_IMM:  v = ex_p_reg;
            SRC_MEMP: v = rd_p_reg;
            SRC_MEMQ: v = rd_q_reg;
            SRC_Q:    v = ex_q_reg;
            SRC_REG:  v = r_src;
            default:  v = 8'd0;
        endcase
        case (d.dst)
            3'd0:    dv = acc_reg;
            3'd1:    dv = x_reg;
            3'd2:    dv = y_reg;
            default: dv = rd_p_reg;
        endcase
        case (d.src_misc)
            2'd0:    push_v = r_src;
            2'd1:    push_v = flag_reg;
            2'd2:    push_v = depth_reg;
            default: push_v = v;
        endcase
        case (d.cond)
            3'd0:    cond_ok = 1'b1;
            3'd1:    cond_ok = (flag_reg & FLAG_EQ) != 8'd0;
            3'd2:    cond_ok = (flag_reg & FLAG_EQ) == 8'd0;
            3'd3:    cond_ok = (flag_reg & FLAG_LT) != 8'd0;
            3'd4:    cond_ok = (flag_reg & (FLAG_LT | FLAG_EQ)) != 8'd0;
            3'd5:    cond_ok = (flag_reg & FLAG_GT) != 8'd0;
            default: cond_ok = (flag_reg & (FLAG_GT | FLAG_EQ)) != 8'd0;
        endcase
        jt = v;
        dif = (d.alu == ALU_CMPR) ? ({1'b0, v} - {1'b0, dv}) : ({1'b0, dv} - {1'b0, v});
        flag_next = flag_reg & ~(FLAG_EQ | FLAG_LT | FLAG_GT);
        if (dif == 9'd0)   flag_next = flag_next | FLAG_EQ;
        else if (dif[8])   flag_next = flag_next | FLAG_LT;
        else               flag_next = flag_next | FLAG_GT;
        case (d.alu)
            ALU_MOV: res = v;
            ALU_ADD: res = dv + v;
            ALU_SUB: res = dv - v;
            ALU_SHL: res = (v >= 8'd8) ? 8'd0 : (dv << v[2:0]);
            ALU_SHR: res = (v >= 8'd8) ? 8'd0 : (dv >> v[2:0]);
            ALU_OR:  res = dv | v;
            ALU_AND: res = dv & v;
            ALU_XOR: res = dv ^ v;
            ALU_POP: res = rd_s_reg;
            default: res = dv;
        endcase
        pc_len = {1'b0, pc_reg} + {15'd0, d.len};
        if ({16'd0, pc_reg} >= 32'(ROM_LIMIT))               err = ERR_ROM;
        else if (d.len == 2'd0)                              err = ERR_OP;
        else if ({15'd0, pc_len} > 32'(ROM_LIMIT))           err = ERR_ROM;
        else if (d.push && {24'd0, depth_reg} >= 32'(STACK_SIZE)) err = ERR_FULL;
        else if (d.pop && depth_reg == 8'd0)                 err = ERR_EMPTY;
        else                                                 err = ERR_OK;
    end

    // memory read stage, with forwarding from the write in the same cycle
    logic          mw_en;
    logic [AW-1:0] mw_a;
    assign mw_en = clr_reg || (ex_go && err == ERR_OK && d.dst == 3'd3 &&
                   d.alu != ALU_CMP && d.alu != ALU_CMPR);
    assign mw_a  = clr_reg ? clr_cnt_reg[AW-1:0] : ex_pa;

    always_ff @(posedge clk)
    begin
        if (mw_en)
        begin
            mem[mw_a] <= clr_reg ? 8'd0 : res;
        end
        if (in_valid && in_ready)
        begin
            rd_p_reg <= (mw_en && mw_a == pa) ? res : mem[pa];
            rd_q_reg <= (mw_en && mw_a == qa) ? res : mem[qa];
            ex_op_reg <= mode;
            ex_p_reg  <= operand_first;
            ex_q_reg  <= operand_second;
        end
        if (ex_go && err == ERR_OK && d.push)
        begin
            stk[SW'(depth_reg)] <= push_v;
        end
        if (in_valid && in_ready)
        begin
            if (ex_go && err == ERR_OK && d.push)
                rd_s_reg <= push_v;
            else
                rd_s_reg <= stk[SW'(depth_reg -
                            ((ex_go && err == ERR_OK && d.pop) ? 8'd2 : 8'd1))];
        end
        if (ex_go)
        begin
            o_acc_reg  <= (err == ERR_OK && d.dst == 3'd0 && d.alu != ALU_CMP &&
                           d.alu != ALU_CMPR) ? res : acc_reg;
            o_x_reg    <= (err == ERR_OK && d.dst == 3'd1 && d.alu != ALU_CMP &&
                           d.alu != ALU_CMPR) ? res : x_reg;
            o_y_reg    <= (err == ERR_OK && d.dst == 3'd2 && d.alu != ALU_CMP &&
                           d.alu != ALU_CMPR) ? res : y_reg;
            o_flag_reg <= (err == ERR_OK && (d.alu == ALU_CMP || d.alu == ALU_CMPR)) ?
                          flag_next : flag_reg;
            o_pc_reg   <= (err != ERR_OK) ? pc_reg :
                          ((d.alu == ALU_JMP && cond_ok) ? {8'd0, jt} : pc_len[15:0]);
            o_err_reg  <= err;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= 8'd0;
            x_reg         <= 8'd0;
            y_reg         <= 8'd0;
            flag_reg      <= 8'd0;
            depth_reg     <= 8'd0;
            pc_reg        <= 16'd0;
            clr_reg       <= 1'b1;
            clr_cnt_reg   <= '0;
            ex_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (clr_reg)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == (AW+1)'(MEM_DEPTH - 1))
                begin
                    clr_reg <= 1'b0;
                end
            end
            if (in_valid && in_ready)
            begin
                ex_valid_reg <= 1'b1;
            end
            else if (ex_go)
            begin
                ex_valid_reg <= 1'b0;
            end
            if (ex_go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (ex_go && err == ERR_OK)
            begin
                if (d.alu != ALU_CMP && d.alu != ALU_CMPR)
                begin
                    if (d.dst == 3'd0) acc_reg <= res;
                    if (d.dst == 3'd1) x_reg   <= res;
                    if (d.dst == 3'd2) y_reg   <= res;
                end
                else
                begin
                    flag_reg <= flag_next;
                end
                if (d.push) depth_reg <= depth_reg + 8'd1;
                if (d.pop)  depth_reg <= depth_reg - 8'd1;
                pc_reg <= (d.alu == ALU_JMP && cond_ok) ? {8'd0, jt} : pc_len[15:0];
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign acc_out    = o_acc_reg;
    assign x_out      = o_x_reg;
    assign y_out      = o_y_reg;
    assign flags_out  = o_flag_reg;
    assign next_pc    = o_pc_reg;
    assign error_code = o_err_reg;

`ifndef SYNTHESIS
    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        {24'd0, depth_reg} <= 32'(STACK_SIZE)) else $error("stack depth overrun");
    a_noacc_clr: assert property (@(posedge clk) disable iff (!rst_n)
        clr_reg |-> !in_ready) else $error("word taken during clear");
    a_err_pc: assert property (@(posedge clk) disable iff (!rst_n)
        (ex_go && err != ERR_OK) |=> $stable(pc_reg)) else $error("pc moved on error");
`endif

endmodule

>>> test/tb.sv
`timescale 1ns / 1ps
module tb;
    import t8ce_pkg::*;

    localparam logic [7:0] OP_JMP_ACC = 8'h2C;
    localparam logic [7:0] OP_MEM_IMM = 8'h7F;
    localparam logic [7:0] OP_PUSH_A  = 8'h43;
    localparam int         WD_LIMIT   = 4000;

    typedef struct {
        logic [7:0]  acc;
        logic [7:0]  x;
        logic [7:0]  y;
        logic [7:0]  flags;
        logic [15:0] pc;
        logic [2:0]  err;
    } cpu_view_t;

    class cpu_scoreboard;
        logic [7:0]  acc, xr, yr, fl;
        logic [15:0] pc;
        logic [7:0]  mem [MEM_DEPTH_DEF];
        logic [7:0]  stk [STACK_SIZE_DEF];
        int          depth;
        int          fails;
        cpu_view_t   pending [$];

        function new();
            acc = 0; xr = 0; yr = 0; fl = 0; pc = 0; depth = 0; fails = 0;
            foreach (mem[i]) mem[i] = 0;
            foreach (stk[i]) stk[i] = 0;
        endfunction

        function logic [7:0] rd(int i);
            return i == 0 ? acc : (i == 1 ? xr : yr);
        endfunction

        function void wr(int i, logic [7:0] v);
            if (i == 0) acc = v;
            else if (i == 1) xr = v;
            else yr = v;
        endfunction

        function int lidx(int op);
            return op < OP_HOLE ? op - OP_LOGIC : op - OP_LOGIC - 1;
        endfunction

        function int op_len(int op);
            if (op == OP_NOP) return 1;
            if (op < OP_SHIFT + 6) return 2;
            if (op < OP_JMP) return ((op - OP_CMP) % 4) < 2 ? 1 : 2;
            if (op <= OP_JMP + 6) return 2;
            if (op < OP_PUSH - 2) return 1;
            if (op < OP_PUSH) return 0;
            if (op < OP_LOGIC) return 1;
            if (op < OP_PUSHV) return op == OP_HOLE ? 0 : ((lidx(op) % 5) < 3 ? 1 : 2);
            if (op < OP_MEMMEM) return 2;
            if (op <= OP_LAST) return ((op - OP_MEMMEM) % 5) < 3 ? 2 : 3;
            return 0;
        endfunction

        function void set_cmp(logic [7:0] a, logic [7:0] b);
            fl = (fl & ~(FLAG_EQ | FLAG_LT | FLAG_GT))
                 | (a == b ? FLAG_EQ : (a < b ? FLAG_LT : FLAG_GT));
        endfunction

        function bit taken(int c);
            case (c)
                0: return 1;
                1: return (fl & FLAG_EQ) != 0;
                2: return (fl & FLAG_EQ) == 0;
                3: return (fl & FLAG_LT) != 0;
                4: return (fl & (FLAG_LT | FLAG_EQ)) != 0;
                5: return (fl & FLAG_GT) != 0;
                default: return (fl & (FLAG_GT | FLAG_EQ)) != 0;
            endcase
        endfunction

        function void push_b(logic [7:0] v);
            stk[depth] = v;
            depth++;
        endfunction

        function logic [7:0] pop_b();
            depth--;
            return stk[depth];
        endfunction

        function void run_op(int op, logic [7:0] p, logic [7:0] q, inout int nxt);
            int k, g, s, r, o;
            logic [7:0] v;
            if (op == OP_NOP) return;
            if (op < OP_SHIFT) begin
                k = op - 1;
                r = (k % 6) / 2;
                v = k[0] ? mem[p] : p;
                g = k / 6;
                wr(r, g == 0 ? v : (g == 1 ? rd(r) + v : rd(r) - v));
            end else if (op < OP_CMP) begin
                k = op - OP_SHIFT;
                if (p >= 8) wr(k % 3, 0);
                else if (k < 3) wr(k % 3, rd(k % 3) << p);
                else wr(k % 3, rd(k % 3) >> p);
            end else if (op < OP_JMP) begin
                k = op - OP_CMP;
                r = k / 4;
                s = k % 4;
                if (s < 2) begin
                    o = (r == 0) ? s + 1 : (r == 1 ? (s == 0 ? 0 : 2) : s);
                    set_cmp(rd(r), rd(o));
                end else if (s == 2) set_cmp(rd(r), p);
                else set_cmp(p, rd(r));
            end else if (op < OP_PUSH - 2) begin
                k = op - OP_JMP;
                g = k / 7;
                if (taken(k % 7)) nxt = g == 0 ? p : rd(g - 1);
            end else if (op < OP_POP) begin
                k = op - OP_PUSH;
                if (k < 3) push_b(rd(k));
                else if (k == 3) push_b(fl);
                else push_b(depth[7:0]);
            end else if (op < OP_LOGIC) begin
                wr(op - OP_POP, pop_b());
            end else if (op < OP_PUSHV) begin
                k = lidx(op);
                g = k / 5;
                s = k % 5;
                v = s < 3 ? rd(s) : (s == 3 ? p : mem[p]);
                if (g < 3) wr(g % 3, rd(g % 3) | v);
                else if (g < 6) wr(g % 3, rd(g % 3) & v);
                else wr(g % 3, rd(g % 3) ^ v);
            end else if (op == OP_PUSHV) push_b(p);
            else if (op == OP_PUSHM) push_b(mem[p]);
            else if (op == OP_POPM) mem[p] = pop_b();
            else begin
                k = op - OP_MEMMEM;
                g = k / 5;
                s = k % 5;
                v = s < 3 ? rd(s) : (s == 3 ? q : mem[q]);
                mem[p] = g == 0 ? v : (g == 1 ? mem[p] + v : mem[p] - v);
            end
        endfunction

        function void note_word(logic [7:0] op, logic [7:0] p, logic [7:0] q);
            int len, nxt;
            bit psh, pp;
            cpu_view_t e;
            len = op_len(op);
            psh = (op >= OP_PUSH && op < OP_POP) || op == OP_PUSHV || op == OP_PUSHM;
            pp = (op >= OP_POP && op < OP_LOGIC) || op == OP_POPM;
            e.err = ERR_OK;
            if (pc >= ROM_LIMIT_DEF) e.err = ERR_ROM;
            else if (len == 0) e.err = ERR_OP;
            else if (pc + len > ROM_LIMIT_DEF) e.err = ERR_ROM;
            else if (psh && depth >= STACK_SIZE_DEF) e.err = ERR_FULL;
            else if (pp && depth == 0) e.err = ERR_EMPTY;
            if (e.err == ERR_OK) begin
                nxt = pc + len;
                run_op(op, p, q, nxt);
                pc = nxt[15:0];
            end
            e.acc = acc; e.x = xr; e.y = yr; e.flags = fl; e.pc = pc;
            pending.push_back(e);
        endfunction

        function void check_result(cpu_view_t a);
            cpu_view_t e;
            if (pending.size() == 0) begin
                $error("result with nothing expected");
                fails++;
                return;
            end
            e = pending.pop_front();
            if (a.acc !== e.acc) begin
                $error("acc_out exp %h got %h", e.acc, a.acc); fails++;
            end
            if (a.x !== e.x) begin
                $error("x_out exp %h got %h", e.x, a.x); fails++;
            end
            if (a.y !== e.y) begin
                $error("y_out exp %h got %h", e.y, a.y); fails++;
            end
            if (a.flags !== e.flags) begin
                $error("flags_out exp %h got %h", e.flags, a.flags); fails++;
            end
            if (a.pc !== e.pc) begin
                $error("next_pc exp %h got %h", e.pc, a.pc); fails++;
            end
            if (a.err !== e.err) begin
                $error("error_code exp %h got %h", e.err, a.err); fails++;
            end
        endfunction
    endclass

    logic        clk = 0;
    logic        rst_n;
    logic        in_valid, in_ready, out_valid, out_ready;
    logic [7:0]  mode, operand_first, operand_second;
    logic [7:0]  acc_out, x_out, y_out, flags_out;
    logic [15:0] next_pc;
    logic [2:0]  error_code;

    cpu_scoreboard sb = new();
    int  tx_idle, rx_idle, rx_hold, quiet;
    bit  fill_stack, climb, run_off;

    tiny_8bit_cpu_execute u_top (.*);

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (rx_hold > 0)
        begin
            rx_hold <= rx_hold - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= $urandom_range(99) >= rx_idle;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result('{acc_out, x_out, y_out, flags_out, next_pc, error_code});
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet > WD_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic send_word(logic [7:0] op, logic [7:0] p, logic [7:0] q);
        while (tx_idle > 0 && $urandom_range(99) < tx_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        mode <= op;
        operand_first <= p;
        operand_second <= q;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sb.note_word(op, p, q);
    endtask

    task automatic send_next();
        logic [7:0] op, p, q;
        int pc;
        pc = sb.pc;
        p = $urandom_range(1) ? $urandom_range(255) : $urandom_range(9);
        q = $urandom;
        if (run_off)
            op = pc < 990 ? OP_MEM_IMM : (pc < ROM_LIMIT_DEF ? OP_NOP : $urandom);
        else if (pc >= ROM_LIMIT_DEF - 2)
        begin
            op = $urandom_range(1) ? OP_MEM_IMM : OP_JMP_ACC;
            if (op == OP_JMP_ACC) climb = 0;
        end
        else if (climb && pc < 990)
            op = OP_MEM_IMM;
        else if (pc >= 990)
            op = OP_NOP;
        else if (fill_stack)
        begin
            op = OP_PUSH_A;
            if (sb.depth == STACK_SIZE_DEF) fill_stack = 0;
        end
        else
            case ($urandom_range(9))
                0: op = $urandom;
                1: op = $urandom_range(OP_POPM, OP_PUSH);
                default: op = $urandom_range(OP_LAST);
            endcase
        send_word(op, p, q);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    initial
    begin
        rst_n = 0; in_valid = 0; out_ready = 0;
        mode = 0; operand_first = 0; operand_second = 0;
        tx_idle = 0; rx_idle = 0; rx_hold = 0; quiet = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1;
        send_word(OP_POP, 8'h00, 8'h00);
        send_word(8'h01, 8'hFF, 8'h00);
        send_word(8'h03, 8'h01, 8'h00);
        send_word(8'h0D, 8'h01, 8'h00);
        send_word(8'h13, 8'h08, 8'h00);
        send_word(8'h14, 8'h00, 8'h00);
        send_word(8'h16, 8'h07, 8'h00);
        send_word(8'h1B, 8'hFF, 8'h00);
        send_word(8'h1C, 8'h00, 8'h00);
        send_word(8'h19, 8'h00, 8'h00);
        send_word(8'h26, 8'h80, 8'h00);
        send_word(8'h27, 8'h10, 8'h00);
        send_word(8'h41, 8'hFF, 8'hFF);
        send_word(8'h42, 8'h00, 8'h00);
        send_word(OP_HOLE, 8'h00, 8'h00);
        send_word(8'h8B, 8'h00, 8'h00);
        send_word(8'hFF, 8'hAA, 8'h55);
        send_word(8'h47, 8'h00, 8'h00);
        send_word(OP_PUSHV, 8'hA5, 8'h00);
        send_word(OP_POPM, 8'h05, 8'h00);
        send_word(8'h80, 8'hFF, 8'h00);
        send_word(8'h8A, 8'h05, 8'hFF);
        send_word(8'h4F, 8'h5A, 8'h00);
        send_word(8'h75, 8'h05, 8'h00);
        send_word(OP_JMP, 8'h00, 8'h00);
        for (int ph = 0; ph < 3; ph++)
        begin
            drain();
            tx_idle = ph == 0 ? 31 : (ph == 1 ? 85 : 0);
            rx_idle = ph == 0 ? 85 : (ph == 1 ? 31 : 0);
            fill_stack = ph == 0;
            climb = ph == 1;
            if (ph == 2)
            begin
                rx_hold = 400;
                repeat (30) send_next();
                drain();
            end
            repeat (300) send_next();
        end
        run_off = 1;
        while (sb.pc < ROM_LIMIT_DEF) send_next();
        repeat (10) send_next();
        drain();
        repeat (20) @(posedge clk);
        if (sb.fails == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
